FILE: hw/rtl/llffa_pkg.sv
`timescale 1ns / 1ps

package llffa_pkg;

  // Block configuration.
  localparam int MAX_CANDIDATES = 8;
  localparam int DEVICE_COUNT   = 16;

  // Fixed field widths of the stream items.
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int ID_W      = 4;
  localparam int CNT_W     = 4;
  localparam int LOAD_W    = 16;

  localparam int DEV_W       = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam int NUM_IDS     = 2 ** ID_W;
  localparam int TREE_LEAVES = 2 ** DEV_W;

  localparam logic [LOAD_W-1:0] LOAD_MAX  = '1;
  localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(MAX_CANDIDATES);

  localparam int IN_BITS    = CNT_W + NUM_SLOTS * ID_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = ID_W + SLOT_W + LOAD_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [DEV_W-1:0] dev_idx_t;
  typedef logic [ID_W-1:0]  dev_id_t;

  // What one device lane offers to the merge tree.
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [LOAD_W-1:0] load;
  } lane_key_t;

  // Update broadcast from the top level to every lane.
  typedef struct packed {
    logic              commit;
    logic              clear;
    logic              found;
    dev_idx_t          win_idx;
    logic [LOAD_W-1:0] new_load;
  } lane_upd_t;

  typedef logic [NUM_IDS-1:0][DEV_W-1:0] dev_map_t;

  // Maps every possible device id onto its load counter.
  function automatic dev_map_t build_dev_map();
    dev_map_t m;
    for (int i = 0; i < NUM_IDS; i++) begin
      m[i] = DEV_W'(i % DEVICE_COUNT);
    end
    return m;
  endfunction

  localparam dev_map_t DEV_MAP = build_dev_map();

  function automatic logic [LOAD_W-1:0] sat_inc(input logic [LOAD_W-1:0] v);
    return (v == LOAD_MAX) ? v : v + 1'b1;
  endfunction

endpackage

FILE: hw/rtl/llffa_lane.sv
`timescale 1ns / 1ps

// One lane per device: holds the load counter and finds the earliest
// valid slot that names this device.
module llffa_lane import llffa_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  dev_idx_t                       lane_id,
  input  logic [NUM_SLOTS-1:0][DEV_W-1:0] slot_dev,
  input  logic [NUM_SLOTS-1:0]           slot_valid,
  input  lane_upd_t                      upd,
  output lane_key_t                      key
);

  logic [LOAD_W-1:0]    load;
  logic [LOAD_W-1:0]    load_next;
  logic [LOAD_W-1:0]    load_eff;
  logic [NUM_SLOTS-1:0] match;

  always_comb begin
    load_eff = upd.clear ? '0 : load;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      match[s] = slot_valid[s] && (slot_dev[s] == lane_id);
    end
    key.hit  = |match;
    key.load = load_eff;
    key.slot = '0;
    for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
      if (match[s]) begin
        key.slot = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    load_next = load;
    if (upd.commit) begin
      if (upd.found && (upd.win_idx == lane_id)) begin
        load_next = upd.new_load;
      end else begin
        load_next = load_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load <= '0;
    end else begin
      load <= load_next;
    end
  end

endmodule

FILE: hw/rtl/llffa_merge.sv
`timescale 1ns / 1ps

// Minimum tree over the device lanes. Order: lanes with a hit first, then
// the smaller load, then the earlier slot.
module llffa_merge import llffa_pkg::*; (
  input  lane_key_t [DEVICE_COUNT-1:0] keys,
  output lane_key_t                    best,
  output dev_idx_t                     best_idx
);

  lane_key_t [TREE_LEAVES-1:0]   leaf_key;
  lane_key_t [2*TREE_LEAVES-1:0] node_key;
  dev_idx_t  [2*TREE_LEAVES-1:0] node_idx;

  for (genvar i = 0; i < TREE_LEAVES; i++) begin : g_leaf
    if (i < DEVICE_COUNT) begin : g_real
      assign leaf_key[i] = keys[i];
    end else begin : g_pad
      assign leaf_key[i] = '0;
    end
  end

  always_comb begin
    node_key = '0;
    node_idx = '0;
    for (int i = 0; i < TREE_LEAVES; i++) begin
      node_key[TREE_LEAVES + i] = leaf_key[i];
      node_idx[TREE_LEAVES + i] = DEV_W'(i);
    end
    for (int n = TREE_LEAVES - 1; n >= 1; n--) begin
      if (node_key[2*n+1].hit &&
          (!node_key[2*n].hit ||
           (node_key[2*n+1].load < node_key[2*n].load) ||
           ((node_key[2*n+1].load == node_key[2*n].load) &&
            (node_key[2*n+1].slot < node_key[2*n].slot)))) begin
        node_key[n] = node_key[2*n+1];
        node_idx[n] = node_idx[2*n+1];
      end else begin
        node_key[n] = node_key[2*n];
        node_idx[n] = node_idx[2*n];
      end
    end
  end

  assign best     = node_key[1];
  assign best_idx = node_idx[1];

endmodule

FILE: hw/rtl/least_loaded_first_fit_assign.sv
`timescale 1ns / 1ps

// Least-loaded device assignment with earliest-slot tie break.
// The input channel (s_*) carries one data object per item: a candidate
// count and up to eight candidate device ids, plus a flag in s_tuser that
// opens a new request and clears every device load counter first.
// The output channel (m_*) returns one item per input item: the chosen
// device, its slot and its new load, or the no-candidate flag in m_tuser
// with all other fields zero when the candidate count is zero.
// An item accepted while the output is empty shows on m_tvalid in the
// next cycle. Throughput is one item per cycle while s_tready is high;
// the counter read, lane compare, merge tree and saturating increment
// form one loop from the load counters back to them, which sets the rate.
// A two-entry output buffer (output register plus skid register) lets the
// block take a new item while a result waits; s_tready drops only when
// both entries are full, that is after the receiver has stalled while a
// further item came in.
// Synchronous reset clears all load counters and empties the output
// buffer; no item is lost or repeated across a stall.
module least_loaded_first_fit_assign import llffa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // candidate_count [3:0], cand_0 [7:4] ... cand_7 [35:32], zero fill
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // first_of_request [0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // chosen_device [3:0], chosen_slot [6:4], new_load [22:7], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  // no_candidate [0]
  output logic                  m_tuser
);

  logic                             accept;
  logic [CNT_W-1:0]                 cand_count;
  logic [CNT_W-1:0]                 cnt_eff;
  dev_id_t [NUM_SLOTS-1:0]          cand;
  logic [NUM_SLOTS-1:0][DEV_W-1:0]  slot_dev;
  logic [NUM_SLOTS-1:0]             slot_valid;
  lane_upd_t                        upd;
  lane_key_t [DEVICE_COUNT-1:0]     keys;
  lane_key_t                        best;
  dev_idx_t                         best_idx;
  logic [LOAD_W-1:0]                inc_load;
  logic [OUT_DATA_W-1:0]            res_data;
  logic                             res_user;

  // Output buffer.
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_user;
  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;
  logic                  skid_user;
  logic                  pop;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign pop      = out_valid && m_tready;

  // Unpack the item and mark the slots that take part.
  always_comb begin
    cand_count = s_tdata[CNT_W-1:0];
    cnt_eff    = (cand_count > CNT_LIMIT) ? CNT_LIMIT : cand_count;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      cand[s]       = s_tdata[CNT_W + s*ID_W +: ID_W];
      slot_dev[s]   = DEV_MAP[cand[s]];
      slot_valid[s] = (CNT_W'(s) < cnt_eff);
    end
  end

  for (genvar d = 0; d < DEVICE_COUNT; d++) begin : g_lane
    llffa_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .lane_id    (DEV_W'(d)),
      .slot_dev   (slot_dev),
      .slot_valid (slot_valid),
      .upd        (upd),
      .key        (keys[d])
    );
  end

  llffa_merge u_merge (
    .keys     (keys),
    .best     (best),
    .best_idx (best_idx)
  );

  assign inc_load = sat_inc(best.load);

  always_comb begin
    upd.commit   = accept;
    upd.clear    = s_tuser;
    upd.found    = best.hit;
    upd.win_idx  = best_idx;
    upd.new_load = inc_load;
  end

  // An item without candidates reports only the flag.
  always_comb begin
    if (best.hit) begin
      res_data = OUT_DATA_W'({inc_load, best.slot, cand[best.slot]});
    end else begin
      res_data = '0;
    end
    res_user = !best.hit;
  end

  // The skid entry is filled only while the output register holds an
  // item that is not being taken, and it drains first.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (pop) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
        out_user <= skid_user;
      end
    end else if (accept) begin
      if (!out_valid || pop) begin
        out_data <= res_data;
        out_user <= res_user;
      end else begin
        skid_data <= res_data;
        skid_user <= res_user;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_user;

endmodule

FILE: hw/rtl/llffa_checker.sv
`timescale 1ns / 1ps

module llffa_sva import llffa_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tuser
);

  // Reset empties the output buffer.
  a_reset_empty : assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // An item taken while the output is empty appears in the next cycle.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> m_tvalid)
    else $error("result missing one cycle after accept");

  // The no-candidate result carries all other fields as zero.
  a_nocand_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("no-candidate result with nonzero fields");

  // An assignment always leaves a load of at least one.
  a_load_nonzero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[ID_W+SLOT_W +: LOAD_W] != '0))
    else $error("assigned device reports zero load");

  // A stalled result holds.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind least_loaded_first_fit_assign llffa_sva u_llffa_sva (.*);
